### src/lcaz_pkg.sv
`timescale 1ns / 1ps

package lcaz_pkg;

    localparam int WINDOW     = 10;

    localparam int RAW_W      = 24;
    localparam int SAMP_W     = 25;
    localparam int DELAY_W    = 8;
    localparam int THR_W      = 23;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int RING_AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = SAMP_W + FILL_W;
    localparam int MAG_W      = SUM_W - 1;
    localparam int CNT_W      = $clog2(MAG_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(2);

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(3);
    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(500);

    localparam logic [11:0] COOL_MS = 12'd3000;
    localparam logic [11:0] HOLD_MS = 12'd1000;

    localparam logic signed [SAMP_W-1:0] SAMP_MAX = SAMP_W'((1 << (SAMP_W - 1)) - 1);
    localparam logic signed [SAMP_W-1:0] SAMP_MIN = -SAMP_MAX;

endpackage

### src/load_cell_average_auto_zero.sv
`timescale 1ns / 1ps

// Moving average of tared load-cell samples with automatic zero tracking. Each transfer is
// either a millisecond tick or a raw sample, and each gives exactly one result. A tick is
// accepted and goes straight to the auto-zero decision. A sample passes through acceptance,
// the ring memory update, the bit-serial divider that forms the mean (one quotient bit per
// cycle over the 28-bit magnitude of the running sum), taking the quotient and the auto-zero
// decision, which waits until the output is free. One item is in work at a time, and the next
// one is taken while the previous result still waits.

module load_cell_average_auto_zero
    import lcaz_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic signed [RAW_W-1:0]      i_raw_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SAMP_W-1:0]     o_avg_weight,
    output logic signed [SAMP_W-1:0]     o_shown_weight,
    output logic                         o_tare_done,
    input  logic                         i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_AZ
    } t_state;

    t_state                     r_state;
    logic                       r_enable;
    logic        [DELAY_W-1:0]  r_delay;
    logic        [THR_W-1:0]    r_thr;
    logic        [RING_AW-1:0]  r_idx;
    logic        [FILL_W-1:0]   r_fill;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMP_W-1:0]   r_mean;
    logic signed [SAMP_W-1:0]   r_offset;
    logic        [TIME_W-1:0]   r_now;
    logic        [TIME_W-1:0]   r_stable;
    logic        [TIME_W-1:0]   r_last_tare;
    logic signed [SAMP_W-1:0]   r_samp;
    logic                       r_out_valid;
    logic signed [SAMP_W-1:0]   r_avg;
    logic signed [SAMP_W-1:0]   r_shown;
    logic                       r_tared;

    logic                       w_accept;
    logic                       w_rd_en;
    logic                       w_wr_en;
    logic        [SAMP_W-1:0]   w_ram_rdata;
    logic                       w_div_done;
    logic signed [SAMP_W-1:0]   w_quot;

    logic signed [SAMP_W:0]     w_diff;
    logic signed [SAMP_W-1:0]   w_tared_samp;
    logic                       w_full;
    logic signed [SUM_W-1:0]    n_sum;
    logic        [FILL_W-1:0]   n_fill;
    logic        [RING_AW-1:0]  n_idx;

    logic        [SAMP_W-1:0]   w_mean_mag;
    logic                       w_below;
    logic        [DELAY_W+11:0] w_cool_ms;
    logic        [DELAY_W+11:0] w_hold_ms;
    logic                       w_cooling;
    logic        [TIME_W-1:0]   w_start;
    logic                       w_held;
    logic                       w_tare;
    logic        [TIME_W-1:0]   n_stable;
    logic signed [SAMP_W:0]     w_off_sum;
    logic signed [SAMP_W-1:0]   n_offset;
    logic                       w_out_free;

    function automatic logic signed [SAMP_W-1:0] sat_samp(input logic signed [SAMP_W:0] v);
        if (v > $signed({SAMP_MAX[SAMP_W-1], SAMP_MAX})) begin
            return SAMP_MAX;
        end else if (v < $signed({SAMP_MIN[SAMP_W-1], SAMP_MIN})) begin
            return SAMP_MIN;
        end
        return v[SAMP_W-1:0];
    endfunction

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_rd_en    = w_accept && i_op;
    assign w_wr_en    = (r_state == S_UPD);
    assign w_out_free = !r_out_valid || i_ready;

    lcaz_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (WINDOW),
        .AW    (RING_AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_idx),
        .i_wdata (r_samp),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    lcaz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_wr_en),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_diff = $signed({{(SAMP_W + 1 - RAW_W){i_raw_sample[RAW_W-1]}}, i_raw_sample})
               - $signed({r_offset[SAMP_W-1], r_offset});
        w_tared_samp = sat_samp(w_diff);

        w_full = (r_fill == FILL_W'(WINDOW));
        n_sum  = r_sum + $signed({{(SUM_W - SAMP_W){r_samp[SAMP_W-1]}}, r_samp})
               - (w_full ? $signed({{(SUM_W - SAMP_W){w_ram_rdata[SAMP_W-1]}}, w_ram_rdata})
                         : SUM_W'(0));
        n_fill = w_full ? r_fill : r_fill + FILL_W'(1);
        n_idx  = (r_idx == RING_AW'(WINDOW - 1)) ? '0 : r_idx + RING_AW'(1);

        w_mean_mag = r_mean[SAMP_W-1] ? SAMP_W'(-r_mean) : SAMP_W'(r_mean);
        w_below    = (w_mean_mag < {(SAMP_W - THR_W)'(0), r_thr});
        w_cool_ms  = r_delay * COOL_MS;
        w_hold_ms  = r_delay * HOLD_MS;
        w_cooling  = ((r_now - r_last_tare) < TIME_W'(w_cool_ms));
        w_start    = (r_stable == '0) ? r_now : r_stable;
        w_held     = ((r_now - w_start) >= TIME_W'(w_hold_ms));
        w_tare     = r_enable && !w_cooling && w_below && w_held;

        if (!r_enable) begin
            n_stable = r_stable;
        end else if (w_cooling || !w_below || w_held) begin
            n_stable = '0;
        end else begin
            n_stable = w_start;
        end

        w_off_sum = $signed({r_offset[SAMP_W-1], r_offset})
                  + $signed({r_mean[SAMP_W-1], r_mean});
        n_offset  = sat_samp(w_off_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_delay     <= DELAY_RST;
            r_thr       <= THR_RST;
            r_idx       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_mean      <= '0;
            r_offset    <= '0;
            r_now       <= '0;
            r_stable    <= '0;
            r_last_tare <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:    r_enable <= i_cfg_data[0];
                    CFG_DELAY:     r_delay  <= i_cfg_data[DELAY_W-1:0];
                    CFG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end

            if ((r_state == S_AZ) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_op) begin
                            r_samp  <= w_tared_samp;
                            r_state <= S_UPD;
                        end else begin
                            r_now   <= r_now + TIME_W'(1);
                            r_state <= S_AZ;
                        end
                    end
                end
                S_UPD: begin
                    r_sum   <= n_sum;
                    r_fill  <= n_fill;
                    r_idx   <= n_idx;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mean  <= w_quot;
                        r_state <= S_AZ;
                    end
                end
                S_AZ: begin
                    if (w_out_free) begin
                        r_stable    <= n_stable;
                        r_tared     <= w_tare;
                        r_avg       <= w_tare ? '0 : r_mean;
                        r_shown     <= (r_enable && w_below) ? '0 : r_mean;
                        if (w_tare) begin
                            r_offset    <= n_offset;
                            r_last_tare <= r_now;
                            r_idx       <= '0;
                            r_fill      <= '0;
                            r_sum       <= '0;
                            r_mean      <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_avg_weight   = r_avg;
    assign o_shown_weight = r_shown;
    assign o_tare_done    = r_tared;

    a_tare_clears_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tare_done) |-> (o_avg_weight == '0))
        else $error("A transfer that reports a tare carries a nonzero average.");

    a_shown_follows_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_shown_weight != '0)) |-> (o_shown_weight == o_avg_weight))
        else $error("The shown weight differs from the average without being forced to zero.");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("The fill count exceeds the window length.");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("The divider finished outside the divide state.");

    a_one_item_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("A second item could be taken while one is still in work.");

endmodule

### src/lcaz_ram.sv
`timescale 1ns / 1ps

module lcaz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lcaz_div.sv
`timescale 1ns / 1ps

module lcaz_div
    import lcaz_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_dividend,
    input  logic        [FILL_W-1:0] i_divisor,
    output logic                     o_done,
    output logic signed [SAMP_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MAG_W-1:0]  r_mag;
    logic [FILL_W-1:0] r_rem;
    logic [FILL_W-1:0] r_div;
    logic              r_neg;

    logic [FILL_W:0]   w_trial;
    logic [FILL_W:0]   w_diff;
    logic              w_ge;
    logic [FILL_W-1:0] n_rem;
    logic [SUM_W-1:0]  w_abs;
    logic [SAMP_W-1:0] w_q;

    always_comb begin
        w_trial = {r_rem, r_mag[MAG_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[FILL_W-1:0] : w_trial[FILL_W-1:0];
        w_abs   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
        w_q     = {1'b0, r_mag[SAMP_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
                r_mag  <= w_abs[MAG_W-1:0];
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
            end else if (r_busy) begin
                r_mag <= {r_mag[MAG_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(w_q) : $signed(w_q);

endmodule
